FILE: hw/rtl/rep_pkg.sv
// rep_pkg: shared types and constants for the rotary encoder button pulse core
// no dependencies; imported by every module of the block

package rep_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS    = 1'd1;

    localparam logic [6:0]  FILTER_LENGTH_RESET = 7'd4;
    localparam logic [15:0] HOLD_TICKS_RESET    = 16'd10;

    // counter saturation for the hold timer
    localparam logic [15:0] HOLD_MAX = 16'hFFFF;

    // button machine modes
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_LEFT  = 2'd1,
        MODE_RIGHT = 2'd2
    } rep_mode_t;

    // move produced by the front end for one item
    typedef struct packed {
        logic valid;
        logic right;
    } rep_move_t;

    // move queue status seen by the button machine
    typedef struct packed {
        logic empty;
        logic head_right;
        logic drop;
    } rep_qstat_t;

endpackage

FILE: hw/rtl/rep_if.sv
// rep_if: valid/ready channel interfaces for encoder samples and button results
// no dependencies

interface rep_in_if;
    logic valid;
    logic ready;
    logic data_level;
    logic clock_level;

    modport source (output valid, output data_level, output clock_level, input ready);
    modport sink   (input valid, input data_level, input clock_level, output ready);
endinterface

interface rep_out_if;
    logic               valid;
    logic               ready;
    logic               left_button;
    logic               right_button;
    logic               overflow_flag;
    logic signed [15:0] position;

    modport source (output valid, output left_button, output right_button,
                    output overflow_flag, output position, input ready);
    modport sink   (input valid, input left_button, input right_button,
                    input overflow_flag, input position, output ready);
endinterface

FILE: hw/rtl/rep_front.sv
// rep_front: line filters, stable levels, half-step move detection and position
// depends on rep_pkg

module rep_front
    import rep_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic               data_level,
    input  logic               clock_level,
    input  logic [6:0]         filter_length,
    output rep_move_t          move,
    output logic signed [15:0] position
);

    logic signed [7:0]  dcnt_reg, dcnt_next;
    logic signed [7:0]  ccnt_reg, ccnt_next;
    logic               sdata_reg, sdata_next;
    logic               sclk_reg, sclk_next;
    logic               primed_reg;
    logic signed [15:0] pos_reg, pos_next;
    logic signed [7:0]  end_pos, end_neg;
    logic               base_d, base_c, nd, nc;

    // effective filter end, zero taken as one
    assign end_pos = (filter_length == 7'd0) ? 8'sd1 : $signed({1'b0, filter_length});
    assign end_neg = -end_pos;

    // first item loads the stable levels straight from the inputs
    assign base_d = primed_reg ? sdata_reg : data_level;
    assign base_c = primed_reg ? sclk_reg  : clock_level;

    // integrating filters
    always_comb
    begin
        dcnt_next = dcnt_reg;
        ccnt_next = ccnt_reg;
        if (data_level)
        begin
            if (dcnt_reg < end_pos)
                dcnt_next = dcnt_reg + 8'sd1;
        end
        else if (dcnt_reg > end_neg)
        begin
            dcnt_next = dcnt_reg - 8'sd1;
        end
        if (clock_level)
        begin
            if (ccnt_reg < end_pos)
                ccnt_next = ccnt_reg + 8'sd1;
        end
        else if (ccnt_reg > end_neg)
        begin
            ccnt_next = ccnt_reg - 8'sd1;
        end
    end

    // stable levels change only at a counter end
    always_comb
    begin
        nd = base_d;
        nc = base_c;
        if (dcnt_next == end_pos)
            nd = 1'b1;
        else if (dcnt_next == end_neg)
            nd = 1'b0;
        if (ccnt_next == end_pos)
            nc = 1'b1;
        else if (ccnt_next == end_neg)
            nc = 1'b0;
    end

    // a change leaving the levels unequal is a move: left when data changed
    assign move.valid = take && ((nd != base_d) || (nc != base_c)) && (nd != nc);
    assign move.right = (nd == base_d);

    assign sdata_next = take ? nd : sdata_reg;
    assign sclk_next  = take ? nc : sclk_reg;

    always_comb
    begin
        pos_next = pos_reg;
        if (move.valid)
            pos_next = move.right ? pos_reg + 16'sd1 : pos_reg - 16'sd1;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg   <= '0;
            ccnt_reg   <= '0;
            sdata_reg  <= 1'b0;
            sclk_reg   <= 1'b0;
            primed_reg <= 1'b0;
            pos_reg    <= '0;
        end
        else
        begin
            if (take)
            begin
                dcnt_reg   <= dcnt_next;
                ccnt_reg   <= ccnt_next;
                primed_reg <= 1'b1;
            end
            sdata_reg <= sdata_next;
            sclk_reg  <= sclk_next;
            pos_reg   <= pos_next;
        end
    end

    assign position = pos_reg;

endmodule

FILE: hw/rtl/rep_queue.sv
// rep_queue: ring buffer of pending moves between front end and button machine
// depends on rep_pkg

module rep_queue
    import rep_pkg::*;
#(
    parameter int BUFFER_DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  rep_move_t  move,
    input  logic       pop,
    output rep_qstat_t status
);

    localparam int PTR_W = $clog2(BUFFER_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);

    logic             mem [BUFFER_DEPTH];
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] wr_inc, rd_inc;
    logic             head_reg;
    logic             full, empty_before, push;

    assign wr_inc = (wr_reg == PTR_LAST) ? '0 : wr_reg + PTR_W'(1);
    assign rd_inc = (rd_reg == PTR_LAST) ? '0 : rd_reg + PTR_W'(1);

    // one slot stays free so that equal pointers mean empty
    assign full         = (wr_inc == rd_reg);
    assign empty_before = (wr_reg == rd_reg);
    assign push         = move.valid && !full;

    assign wr_next = push ? wr_inc : wr_reg;
    assign rd_next = pop ? rd_inc : rd_reg;

    // status after this item's push; a move into an empty queue is its own head
    assign status.drop       = move.valid && full;
    assign status.empty      = (wr_next == rd_reg);
    assign status.head_right = empty_before ? move.right : head_reg;

    // move store, written at the tail and read at the next head
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= move.right;
        if (push && (wr_reg == rd_next))
            head_reg <= move.right;
        else
            head_reg <= mem[rd_next];
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
            wr_reg <= '0;
        end
        else
        begin
            rd_reg <= rd_next;
            wr_reg <= wr_next;
        end
    end

endmodule

FILE: hw/rtl/rep_back.sv
// rep_back: button press machine, overflow handling and result register
// depends on rep_pkg

module rep_back
    import rep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic        out_ready,
    input  logic [15:0] hold_ticks,
    input  rep_qstat_t  status,
    output logic        pop,
    output logic        slot_free,
    output logic        out_valid,
    output logic        left_button,
    output logic        right_button,
    output logic        overflow_flag
);

    rep_mode_t   mode_reg, mode_next;
    logic [15:0] hc_reg, hc_next, hc_inc;
    logic        left_reg, left_next;
    logic        right_reg, right_next;
    logic        ovf_reg, ovf_next, ovf_now;
    logic        valid_reg;

    assign hc_inc  = (hc_reg == HOLD_MAX) ? hc_reg : hc_reg + 16'd1;
    assign ovf_now = ovf_reg | status.drop;

    // next state and button levels for one item
    always_comb
    begin
        mode_next  = mode_reg;
        hc_next    = hc_reg;
        left_next  = left_reg;
        right_next = right_reg;
        ovf_next   = ovf_reg;
        pop        = 1'b0;
        if (take)
        begin
            ovf_next = ovf_now;
            unique case (mode_reg)
                MODE_LEFT, MODE_RIGHT:
                begin
                    hc_next = hc_inc;
                    if (hc_inc >= hold_ticks)
                    begin
                        if (!ovf_now)
                        begin
                            if (mode_reg == MODE_LEFT)
                                left_next = 1'b0;
                            else
                                right_next = 1'b0;
                        end
                        mode_next = MODE_IDLE;
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                    if (status.empty)
                    begin
                        if (ovf_now)
                        begin
                            ovf_next   = 1'b0;
                            left_next  = 1'b0;
                            right_next = 1'b0;
                        end
                    end
                    else
                    begin
                        pop     = 1'b1;
                        hc_next = '0;
                        if (status.head_right)
                        begin
                            mode_next = MODE_RIGHT;
                            if (!ovf_now)
                                right_next = 1'b1;
                        end
                        else
                        begin
                            mode_next = MODE_LEFT;
                            if (!ovf_now)
                                left_next = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            hc_reg    <= '0;
            left_reg  <= 1'b0;
            right_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            hc_reg    <= hc_next;
            left_reg  <= left_next;
            right_reg <= right_next;
            ovf_reg   <= ovf_next;
        end
    end

    // result slot: levels only change when a new item is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    assign slot_free     = !valid_reg || out_ready;
    assign out_valid     = valid_reg;
    assign left_button   = left_reg;
    assign right_button  = right_reg;
    assign overflow_flag = ovf_reg;

endmodule

FILE: hw/rtl/rotary_encoder_to_button_pulses_core.sv
// rotary_encoder_to_button_pulses_core: top level of the encoder to button pulse block
// depends on rep_pkg, rep_if, rep_front, rep_queue, rep_back
//
//   channel    dir  handshake          payload
//   item_in    in   valid / ready      data_level, clock_level
//   item_out   out  valid / ready      left_button, right_button, overflow_flag, position
//   cfg        in   cfg_we             cfg_index, cfg_data
//
// one item per clock while the result register is free; each item gives its result on the next cycle
// the single result register sets the rate: a new item is taken whenever the
// register is empty or being read in the same cycle
// reset clears filters, pointers and the button machine; no clearing pass
// a stall on item_out holds item_in off; the move queue never stalls

module rotary_encoder_to_button_pulses_core
    import rep_pkg::*;
#(
    parameter int BUFFER_DEPTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    rep_in_if.sink                item_in,
    rep_out_if.source             item_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [6:0]  filter_length_reg;
    logic [15:0] hold_ticks_reg;
    logic        take, pop, slot_free;
    rep_move_t   move;
    rep_qstat_t  status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_length_reg <= FILTER_LENGTH_RESET;
            hold_ticks_reg    <= HOLD_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FILTER_LENGTH: filter_length_reg <= cfg_data[6:0];
                CFG_HOLD_TICKS:    hold_ticks_reg    <= cfg_data[15:0];
            endcase
        end
    end

    // item handshake
    assign item_in.ready = slot_free;
    assign take          = item_in.valid && slot_free;

    rep_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .data_level    (item_in.data_level),
        .clock_level   (item_in.clock_level),
        .filter_length (filter_length_reg),
        .move          (move),
        .position      (item_out.position)
    );

    rep_queue #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .move   (move),
        .pop    (pop),
        .status (status)
    );

    rep_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .out_ready     (item_out.ready),
        .hold_ticks    (hold_ticks_reg),
        .status        (status),
        .pop           (pop),
        .slot_free     (slot_free),
        .out_valid     (item_out.valid),
        .left_button   (item_out.left_button),
        .right_button  (item_out.right_button),
        .overflow_flag (item_out.overflow_flag)
    );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for rotary_encoder_to_button_pulses_core
// depends on rep_pkg, rep_if and the core; scores every result against an in-bench predictor or a typed row

module testbench;
    import rep_pkg::*;

    localparam int QUEUE_DEPTH = 16;

    typedef struct packed {
        logic        left;
        logic        right;
        logic        ovf;
        logic [15:0] pos;
    } poll_result_t;

    typedef struct {
        bit           typed;
        poll_result_t want;
    } poll_note_t;

    typedef struct packed {
        bit           d;
        bit           c;
        bit           typed;
        poll_result_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rep_in_if  poll_if ();
    rep_out_if btn_if ();

    rotary_encoder_to_button_pulses_core #(.BUFFER_DEPTH(QUEUE_DEPTH)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (poll_if),
        .item_out  (btn_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the configuration and the block state
    logic [6:0]  filt_cfg = FILTER_LENGTH_RESET;
    logic [15:0] hold_cfg = HOLD_TICKS_RESET;
    int          data_integ = 0;
    int          clock_integ = 0;
    bit          settled_data = 0;
    bit          settled_clock = 0;
    bit          seeded = 0;
    bit          moves_right [QUEUE_DEPTH];
    int          head_ptr = 0;
    int          tail_ptr = 0;
    bit          overrun = 0;
    rep_mode_t   btn_mode = MODE_IDLE;
    logic [15:0] held_ticks = '0;
    bit          left_lvl = 0;
    bit          right_lvl = 0;
    logic [15:0] detent = '0;

    poll_result_t button_forecast [$];
    poll_note_t   item_notes [$];
    int           fail_count = 0;
    int           results_seen = 0;
    bit           tx_calm = 0;
    bit           rx_calm = 0;
    int           quad_idx = 3;
    int           spin_dir = 1;
    bit [1:0]     quad_code [4] = '{2'b00, 2'b01, 2'b11, 2'b10};

    // short directed walk at filter length one and zero hold: both directions,
    // a double change to equal levels and a double change to unequal levels
    dir_row_t dir_rows [24] = '{
        {1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0},
        {1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0},
        {1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0},
        {1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 16'd1},
        {1'b1, 1'b1, 1'b0, 19'd0}, {1'b1, 1'b1, 1'b0, 19'd0},
        {1'b1, 1'b0, 1'b0, 19'd0}, {1'b1, 1'b0, 1'b0, 19'd0},
        {1'b0, 1'b0, 1'b0, 19'd0}, {1'b0, 1'b0, 1'b0, 19'd0},
        {1'b1, 1'b0, 1'b0, 19'd0}, {1'b1, 1'b0, 1'b0, 19'd0},
        {1'b1, 1'b1, 1'b0, 19'd0}, {1'b1, 1'b1, 1'b0, 19'd0},
        {1'b0, 1'b1, 1'b0, 19'd0}, {1'b0, 1'b1, 1'b0, 19'd0},
        {1'b0, 1'b0, 1'b0, 19'd0}, {1'b0, 1'b0, 1'b0, 19'd0},
        {1'b1, 1'b1, 1'b0, 19'd0}, {1'b1, 1'b1, 1'b0, 19'd0},
        {1'b0, 1'b1, 1'b0, 19'd0}, {1'b0, 1'b1, 1'b0, 19'd0},
        {1'b1, 1'b0, 1'b0, 19'd0}, {1'b1, 1'b0, 1'b0, 19'd0}
    };

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // integrating line filter, saturating at plus or minus the end
    function automatic int filter_step(int cnt, bit lvl, int lim);
        if (lvl && cnt < lim)
            return cnt + 1;
        if (!lvl && -cnt < lim)
            return cnt - 1;
        return cnt;
    endfunction

    // one poll tick: encoder front end first, then the button machine
    function automatic poll_result_t predict_poll(bit d, bit c);
        int           lim;
        int           count;
        bit           nd;
        bit           nc;
        bit           to_right;
        poll_result_t res;
        lim = (filt_cfg == 0) ? 1 : int'(filt_cfg);
        if (!seeded)
        begin
            settled_data  = d;
            settled_clock = c;
            seeded        = 1;
        end
        nd = settled_data;
        nc = settled_clock;
        data_integ = filter_step(data_integ, d, lim);
        if (data_integ == lim)
            nd = 1;
        else if (data_integ == -lim)
            nd = 0;
        clock_integ = filter_step(clock_integ, c, lim);
        if (clock_integ == lim)
            nc = 1;
        else if (clock_integ == -lim)
            nc = 0;

        // half-step move on a change that leaves the levels unequal
        if (nd != settled_data || nc != settled_clock)
        begin
            if (nd != nc)
            begin
                to_right = (nd == settled_data);
                detent   = to_right ? detent + 16'd1 : detent - 16'd1;
                count    = (tail_ptr + QUEUE_DEPTH - head_ptr) % QUEUE_DEPTH;
                if (count == QUEUE_DEPTH - 1)
                    overrun = 1;
                else
                begin
                    moves_right[tail_ptr] = to_right;
                    tail_ptr = (tail_ptr + 1) % QUEUE_DEPTH;
                end
            end
            settled_data  = nd;
            settled_clock = nc;
        end

        // button machine
        if (btn_mode == MODE_LEFT || btn_mode == MODE_RIGHT)
        begin
            if (held_ticks != HOLD_MAX)
                held_ticks = held_ticks + 16'd1;
            if (held_ticks >= hold_cfg)
            begin
                if (!overrun)
                begin
                    if (btn_mode == MODE_LEFT)
                        left_lvl = 0;
                    else
                        right_lvl = 0;
                end
                btn_mode = MODE_IDLE;
            end
        end
        else
        begin
            btn_mode = MODE_IDLE;
            if (head_ptr == tail_ptr)
            begin
                if (overrun)
                begin
                    overrun   = 0;
                    left_lvl  = 0;
                    right_lvl = 0;
                end
            end
            else
            begin
                if (moves_right[head_ptr])
                begin
                    btn_mode = MODE_RIGHT;
                    if (!overrun)
                        right_lvl = 1;
                end
                else
                begin
                    btn_mode = MODE_LEFT;
                    if (!overrun)
                        left_lvl = 1;
                end
                head_ptr   = (head_ptr + 1) % QUEUE_DEPTH;
                held_ticks = '0;
            end
        end
        res.left  = left_lvl;
        res.right = right_lvl;
        res.ovf   = overrun;
        res.pos   = detent;
        return res;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic check_field(string tag, int want_v, int got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, tag, want_v, got_v);
            fail_count++;
        end
    endtask

    // scoreboard: predict on each accepted item, compare each accepted result
    always @(posedge clk)
    begin : watch
        poll_result_t p;
        poll_result_t want;
        poll_note_t   note;
        if (rst_n)
        begin
            if (poll_if.valid && poll_if.ready)
            begin
                p = predict_poll(poll_if.data_level, poll_if.clock_level);
                if (item_notes.size() != 0)
                begin
                    note = item_notes.pop_front();
                    button_forecast.push_back(note.typed ? note.want : p);
                end
                else
                    button_forecast.push_back(p);
            end
            if (btn_if.valid && btn_if.ready)
            begin
                results_seen++;
                if (button_forecast.size() == 0)
                begin
                    $display("%0t: result with no item outstanding, actual pos %0d",
                             $time, $signed(btn_if.position));
                    fail_count++;
                end
                else
                begin
                    want = button_forecast.pop_front();
                    check_field("left_button", want.left, btn_if.left_button);
                    check_field("right_button", want.right, btn_if.right_button);
                    check_field("overflow_flag", want.ovf, btn_if.overflow_flag);
                    check_field("position", $signed(want.pos), $signed(btn_if.position));
                end
            end
        end
    end

    // result side: random stalls, calm stretches and one long hold-off
    initial
    begin : sink_side
        int  stall_left;
        bit  long_done;
        int  g;
        stall_left = 0;
        long_done  = 0;
        btn_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 63) == 0)
                rx_calm = !rx_calm;
            if (stall_left > 0)
            begin
                stall_left--;
                btn_if.ready <= 1'b0;
            end
            else if (!long_done && results_seen >= 400)
            begin
                long_done  = 1;
                stall_left = 120;
                btn_if.ready <= 1'b0;
            end
            else if (rx_calm)
                btn_if.ready <= 1'b1;
            else
            begin
                g = gap_len();
                if (g > 0)
                begin
                    stall_left = g - 1;
                    btn_if.ready <= 1'b0;
                end
                else
                    btn_if.ready <= 1'b1;
            end
        end
    end

    // offer one item, entered and left at a falling edge
    task automatic send_poll(bit d, bit c, bit typed, poll_result_t want);
        int         g;
        poll_note_t note;
        if ($urandom_range(0, 63) == 0)
            tx_calm = !tx_calm;
        g = tx_calm ? 0 : gap_len();
        if (g > 0)
        begin
            poll_if.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        note.typed = typed;
        note.want  = want;
        item_notes.push_back(note);
        poll_if.valid       <= 1'b1;
        poll_if.data_level  <= d;
        poll_if.clock_level <= c;
        @(posedge clk);
        while (!poll_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_quiet();
        poll_if.valid <= 1'b0;
        while (button_forecast.size() != 0 || item_notes.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // both registers, written back to back while the block is idle
    task automatic set_config(logic [6:0] filt, logic [15:0] hold_v);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FILTER_LENGTH;
        cfg_data  <= {9'd0, filt};
        @(negedge clk);
        cfg_index <= CFG_HOLD_TICKS;
        cfg_data  <= hold_v;
        @(negedge clk);
        cfg_we <= 1'b0;
        filt_cfg = filt;
        hold_cfg = hold_v;
    endtask

    // rotation with random dwell, double flips and bursts of noise
    task automatic run_phase(logic [6:0] filt, logic [15:0] hold_v, int n_items);
        int       sent;
        int       lim;
        int       dwell;
        int       r;
        bit [1:0] lv;
        wait_quiet();
        set_config(filt, hold_v);
        lim  = (filt == 0) ? 1 : int'(filt);
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                dwell = $urandom_range(1, 3);
                for (int k = 0; k < dwell && sent < n_items; k++)
                begin
                    send_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
                    sent++;
                end
            end
            else
            begin
                if (r < 14)
                    quad_idx = (quad_idx + 2) % 4;
                else
                begin
                    if ($urandom_range(0, 7) == 0)
                        spin_dir = -spin_dir;
                    quad_idx = (quad_idx + spin_dir + 4) % 4;
                end
                dwell = (r < 24) ? $urandom_range(1, 2 * lim) : 2 * lim + $urandom_range(0, 2);
                lv = quad_code[quad_idx];
                for (int k = 0; k < dwell && sent < n_items; k++)
                begin
                    send_poll(lv[1], lv[0], 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    // stimulus and end of run
    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        poll_if.valid       = 1'b0;
        poll_if.data_level  = 1'b0;
        poll_if.clock_level = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_config(7'd1, 16'd0);
        for (int i = 0; i < 24; i++)
            send_poll(dir_rows[i].d, dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);

        run_phase(7'd2, 16'd3, 180);
        // widest filter, then a lower length with counters still out at the far end
        run_phase(7'd127, 16'd1, 330);
        run_phase(7'd3, 16'd2, 90);
        // zero length behaves as one
        run_phase(7'd0, 16'd0, 90);
        // longest hold: queue fills and overflows
        run_phase(7'd1, 16'd65535, 140);
        // quick release drains the queue and clears overflow
        run_phase(7'd2, 16'd0, 160);
        run_phase(7'd4, 16'd10, 90);

        wait_quiet();
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
